@@ src/psg_opm_sound_port_interface_top_assert.svh @@
// Assertion macros used by the sound port interface controller.
`ifndef PSG_OPM_SOUND_PORT_INTERFACE_TOP_ASSERT_SVH
`define PSG_OPM_SOUND_PORT_INTERFACE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSGOPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psgopm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSGOPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psgopm assertion failed");

`endif

@@ src/psgopm_pkg.sv @@
// ----------------------------------------------------------------------------
// psgopm_pkg
// Types and constants of the PSG/OPM sound port interface.
// ----------------------------------------------------------------------------
package psgopm_pkg;

    localparam logic [2:0] OP_PSG_INDEX = 3'd0;
    localparam logic [2:0] OP_PSG_DATA  = 3'd1;
    localparam logic [2:0] OP_PSG_READ  = 3'd2;
    localparam logic [2:0] OP_OPM_WRITE = 3'd3;
    localparam logic [2:0] OP_OPM_READ  = 3'd4;

    localparam logic [1:0] CFG_KEY_PORT    = 2'd0;
    localparam logic [1:0] CFG_RAPID_FIRE  = 2'd1;
    localparam logic [1:0] CFG_BUTTON_SWAP = 2'd2;

    localparam int          MIXER_REG       = 7;
    localparam logic [7:0]  MIXER_RESET     = 8'h3f;
    localparam logic [7:0]  KEY_PORT_BASE   = 8'h0d;
    localparam logic [7:0]  PAD_PORT_INDEX  = 8'h0e;
    localparam logic [7:0]  JOY_LIMIT       = 8'h10;
    localparam logic [7:0]  FLOAT_BUS       = 8'hff;
    localparam logic [7:0]  OPM_INDEX_PORT  = 8'h00;
    localparam logic [7:0]  OPM_DATA_PORT   = 8'h01;
    localparam logic [7:0]  TIMER_PORT_MASK = 8'hfc;
    localparam logic [7:0]  TIMER_PORT_BASE = 8'h04;
    localparam logic [7:0]  OPM_PAIR_MASK   = 8'hfe;
    localparam logic [7:0]  SWAP_KEEP_MASK  = 8'h9f;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ src/psgopm_if.sv @@
// ----------------------------------------------------------------------------
// psgopm_if
// Channel interfaces: port access beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface psgopm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] port_low;
    logic [7:0] write_data;
    logic [7:0] keyboard_joy;
    logic [7:0] pad_joy;

    modport source (output valid, operation, port_low, write_data, keyboard_joy, pad_joy,
                    input ready);
    modport sink (input valid, operation, port_low, write_data, keyboard_joy, pad_joy,
                  output ready);
endinterface

interface psgopm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timer_access;
    logic [1:0] timer_port;
    logic       sound_write;
    logic       sound_chip;
    logic [7:0] sound_reg;
    logic [7:0] sound_data;

    modport source (output valid, read_data, timer_access, timer_port, sound_write,
                    sound_chip, sound_reg, sound_data, input ready);
    modport sink (input valid, read_data, timer_access, timer_port, sound_write,
                  sound_chip, sound_reg, sound_data, output ready);
endinterface

interface psgopm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/psgopm_ctrl.sv @@
// ----------------------------------------------------------------------------
// psgopm_ctrl
// Controller that sequences capture, execution and result delivery.
// ----------------------------------------------------------------------------
`include "psg_opm_sound_port_interface_top_assert.svh"

module psgopm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output psgopm_pkg::t_cmd   o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic slot_free;

    assign slot_free     = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.execute = (r_state == ST_EXEC) && slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (o_cmd.execute) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PSGOPM_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, o_cmd.capture, r_state == ST_EXEC)
    `PSGOPM_ASSERT_NEXT(a_exec_gives_beat, i_clk, i_rst_n, o_cmd.execute, r_out_valid)
    `PSGOPM_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, r_state == ST_EXEC, !o_in_ready)
    `PSGOPM_ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n,
        (r_state == ST_EXEC) && r_out_valid && !i_out_ready, r_state == ST_EXEC)

endmodule

@@ src/psgopm_dp.sv @@
// ----------------------------------------------------------------------------
// psgopm_dp
// Datapath: index latches, PSG register file, joystick readback, result regs.
// ----------------------------------------------------------------------------
module psgopm_dp #(
    parameter int PSG_REG_COUNT = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psgopm_pkg::t_cmd   i_cmd,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_port_low,
    input  logic [7:0]         i_write_data,
    input  logic [7:0]         i_keyboard_joy,
    input  logic [7:0]         i_pad_joy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic [7:0]         o_read_data,
    output logic               o_timer_access,
    output logic [1:0]         o_timer_port,
    output logic               o_sound_write,
    output logic               o_sound_chip,
    output logic [7:0]         o_sound_reg,
    output logic [7:0]         o_sound_data
);

    localparam int         IW        = $clog2(PSG_REG_COUNT);
    localparam logic [7:0] REG_COUNT = 8'(PSG_REG_COUNT);

    logic [2:0] r_op;
    logic [7:0] r_port;
    logic [7:0] r_wdata;
    logic [7:0] r_kbd;
    logic [7:0] r_pad;

    logic [7:0] r_psg_index;
    logic [7:0] r_opm_index;
    logic [1:0] r_rapid;
    logic [1:0] n_rapid;
    logic [7:0] r_psg_regs [PSG_REG_COUNT];

    logic [1:0] r_key_port;
    logic       r_rapid_en;
    logic       r_swap_en;

    logic [7:0] n_read_data;
    logic       n_timer_access;
    logic [1:0] n_timer_port;
    logic       n_sound_write;
    logic       n_sound_chip;
    logic [7:0] n_sound_reg;
    logic [7:0] n_sound_data;

    logic       in_file;
    logic       in_joy;
    logic       timer_hit;
    logic [7:0] file_data;
    logic [7:0] joy_raw;
    logic [7:0] joy_fire;
    logic [7:0] joy_data;

    assign in_file   = (r_psg_index < REG_COUNT);
    assign in_joy    = (r_psg_index < psgopm_pkg::JOY_LIMIT);
    assign timer_hit = ((r_port & psgopm_pkg::TIMER_PORT_MASK) == psgopm_pkg::TIMER_PORT_BASE);
    assign file_data = r_psg_regs[r_psg_index[IW-1:0]];

    always_comb begin
        joy_raw = psgopm_pkg::FLOAT_BUS;
        if (r_psg_index == ({6'd0, r_key_port} + psgopm_pkg::KEY_PORT_BASE)) begin
            joy_raw = joy_raw & r_kbd;
        end
        if (r_psg_index == psgopm_pkg::PAD_PORT_INDEX) begin
            joy_raw = joy_raw & r_pad;
        end
        n_rapid  = r_rapid ^ 2'b11;
        joy_fire = r_rapid_en ? (joy_raw | {1'b0, n_rapid, 5'd0}) : joy_raw;
        joy_data = r_swap_en ? ((joy_fire & psgopm_pkg::SWAP_KEEP_MASK)
                               | {1'b0, joy_fire[5], joy_fire[6], 5'd0}) : joy_fire;
    end

    always_comb begin
        n_read_data    = 8'h00;
        n_timer_access = 1'b0;
        n_timer_port   = 2'd0;
        n_sound_write  = 1'b0;
        n_sound_chip   = 1'b0;
        n_sound_reg    = 8'h00;
        n_sound_data   = 8'h00;
        case (r_op)
            psgopm_pkg::OP_PSG_DATA: begin
                if (in_file) begin
                    n_sound_write = 1'b1;
                    n_sound_reg   = r_psg_index;
                    n_sound_data  = r_wdata;
                end
            end
            psgopm_pkg::OP_PSG_READ: begin
                if (in_file) begin
                    n_read_data = file_data;
                end else if (in_joy) begin
                    n_read_data = joy_data;
                end else begin
                    n_read_data = psgopm_pkg::FLOAT_BUS;
                end
            end
            psgopm_pkg::OP_OPM_WRITE: begin
                if (r_port == psgopm_pkg::OPM_DATA_PORT) begin
                    n_sound_write = 1'b1;
                    n_sound_chip  = 1'b1;
                    n_sound_reg   = r_opm_index;
                    n_sound_data  = r_wdata;
                end else if (timer_hit) begin
                    n_timer_access = 1'b1;
                    n_timer_port   = r_port[1:0];
                end
            end
            psgopm_pkg::OP_OPM_READ: begin
                if ((r_port & psgopm_pkg::OPM_PAIR_MASK) == psgopm_pkg::OPM_INDEX_PORT) begin
                    n_read_data = 8'h00;
                end else if (timer_hit) begin
                    n_timer_access = 1'b1;
                    n_timer_port   = r_port[1:0];
                end else begin
                    n_read_data = psgopm_pkg::FLOAT_BUS;
                end
            end
            default: begin
                n_read_data = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_port  <= i_port_low;
            r_wdata <= i_write_data;
            r_kbd   <= i_keyboard_joy;
            r_pad   <= i_pad_joy;
        end
        if (i_cmd.execute) begin
            o_read_data    <= n_read_data;
            o_timer_access <= n_timer_access;
            o_timer_port   <= n_timer_port;
            o_sound_write  <= n_sound_write;
            o_sound_chip   <= n_sound_chip;
            o_sound_reg    <= n_sound_reg;
            o_sound_data   <= n_sound_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psg_index <= 8'h00;
            r_opm_index <= 8'h00;
            r_rapid     <= 2'd0;
            r_key_port  <= 2'd0;
            r_rapid_en  <= 1'b0;
            r_swap_en   <= 1'b0;
            for (int k = 0; k < PSG_REG_COUNT; k++) begin
                r_psg_regs[k] <= (k == psgopm_pkg::MIXER_REG) ? psgopm_pkg::MIXER_RESET : 8'h00;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psgopm_pkg::CFG_KEY_PORT:    r_key_port <= i_cfg_data[1:0];
                    psgopm_pkg::CFG_RAPID_FIRE:  r_rapid_en <= i_cfg_data[0];
                    psgopm_pkg::CFG_BUTTON_SWAP: r_swap_en  <= i_cfg_data[0];
                    default: begin
                        r_key_port <= r_key_port;
                    end
                endcase
            end
            if (i_cmd.execute) begin
                case (r_op)
                    psgopm_pkg::OP_PSG_INDEX: begin
                        r_psg_index <= r_wdata;
                    end
                    psgopm_pkg::OP_PSG_DATA: begin
                        if (in_file) begin
                            r_psg_regs[r_psg_index[IW-1:0]] <= r_wdata;
                        end
                    end
                    psgopm_pkg::OP_PSG_READ: begin
                        if (!in_file && in_joy && r_rapid_en) begin
                            r_rapid <= n_rapid;
                        end
                    end
                    psgopm_pkg::OP_OPM_WRITE: begin
                        if (r_port == psgopm_pkg::OPM_INDEX_PORT) begin
                            r_opm_index <= r_wdata;
                        end
                    end
                    default: begin
                        r_rapid <= r_rapid;
                    end
                endcase
            end
        end
    end

endmodule

@@ src/psg_opm_sound_port_interface_top.sv @@
// ----------------------------------------------------------------------------
// psg_opm_sound_port_interface_top
// Bus-side PSG and OPM register interface of a sound board.
// ----------------------------------------------------------------------------
// Each access beat is first captured and then, once the output slot is free,
// evaluated against the index latches and the PSG register file to load the
// result register, and a new access is taken while the previous result beat
// still waits at the output. Results come in order, one per access. Register
// writes are always ready and take effect at the next cycle.
module psg_opm_sound_port_interface_top #(
    parameter int PSG_REG_COUNT = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psgopm_in_if.sink    i_in,
    psgopm_out_if.source o_out,
    psgopm_cfg_if.sink   i_cfg
);

    psgopm_pkg::t_cmd cmd;
    logic             in_ready;
    logic             out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    psgopm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    psgopm_dp #(
        .PSG_REG_COUNT (PSG_REG_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_in.operation),
        .i_port_low     (i_in.port_low),
        .i_write_data   (i_in.write_data),
        .i_keyboard_joy (i_in.keyboard_joy),
        .i_pad_joy      (i_in.pad_joy),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_read_data    (o_out.read_data),
        .o_timer_access (o_out.timer_access),
        .o_timer_port   (o_out.timer_port),
        .o_sound_write  (o_out.sound_write),
        .o_sound_chip   (o_out.sound_chip),
        .o_sound_reg    (o_out.sound_reg),
        .o_sound_data   (o_out.sound_data)
    );

endmodule
